/* rtl/ebtl_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the energy-binned track-length histogram.
// Holds the command codes, field widths and the energy edge table; no dependencies.
package ebtl_pkg;

	localparam int NUM_BINS       = 34;
	localparam int NUM_EDGES      = NUM_BINS + 1;
	localparam int SUM_WIDTH_DEF  = 48;
	localparam int CMD_W          = 2;
	localparam int ENERGY_W       = 44;
	localparam int LEN_W          = 32;
	localparam int BIN_W          = 6;
	localparam int OUT_W          = 48;
	localparam int ADDR_W         = $clog2(NUM_BINS);

	localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

	// Lower edges of the bins, in units of 1e-9 MeV, in rising order.
	localparam logic [ENERGY_W-1:0] EDGES [NUM_EDGES] = '{
		44'd1, 44'd10, 44'd100, 44'd1000, 44'd10000, 44'd100000, 44'd1000000,
		44'd10000000, 44'd100000000,
		44'd200000000, 44'd300000000, 44'd400000000, 44'd500000000,
		44'd600000000, 44'd700000000, 44'd800000000, 44'd900000000,
		44'd1000000000,
		44'd2000000000, 44'd3000000000, 44'd4000000000, 44'd5000000000,
		44'd6000000000, 44'd7000000000, 44'd8000000000, 44'd9000000000,
		44'd10000000000,
		44'd20000000000, 44'd50000000000, 44'd100000000000, 44'd200000000000,
		44'd500000000000, 44'd1000000000000, 44'd5000000000000,
		44'd10000000000000
	};

endpackage

/* rtl/energy_binned_track_length_histogram_unit.sv */
`timescale 1ns / 1ps
// Pipeline: two register stages, the read stage and the output registers; a result item
// is registered from the read stage once the result side does not stall it.
// Throughput: one item per cycle while the result side does not stall; the bin memory
// read of one item overlaps the write-back of the item ahead, which is forwarded to it.
// Reset: arst_n clears all bin sums (via per-bin valid bits) and the total at once.
// Depends on ebtl_pkg, ebtl_bin_locate and ebtl_sum_mem.
module energy_binned_track_length_histogram_unit
	import ebtl_pkg::*;
#(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic                is_neutron,
	input  logic [ENERGY_W-1:0] energy,
	input  logic [LEN_W-1:0]    step_length,
	input  logic [BIN_W-1:0]    read_bin,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic [BIN_W-1:0]    bin_index,
	output logic [OUT_W-1:0]    bin_sum,
	output logic [OUT_W-1:0]    total_sum,
	output logic                saturated
);

	localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

	logic                 in_accept;
	logic                 advance;
	logic [BIN_W-1:0]     hit_bin;
	logic [BIN_W-1:0]     rd_bin;
	logic                 hit_in;

	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic                 hit_s1;
	logic [LEN_W-1:0]     len_s1;
	logic [BIN_W-1:0]     bin_s1;
	logic                 fwd_s1;
	logic [SUM_WIDTH-1:0] fwd_data_s1;

	logic [SUM_WIDTH-1:0] total_q;
	logic [SUM_WIDTH-1:0] mem_rd_data;
	logic [SUM_WIDTH-1:0] old_sum;
	logic [SUM_WIDTH:0]   bin_add;
	logic [SUM_WIDTH:0]   tot_add;
	logic [SUM_WIDTH-1:0] new_bin_sum;
	logic [SUM_WIDTH-1:0] new_total;
	logic                 clr_s1;
	logic                 fwd_next;

	logic                 res_accepted;
	logic [BIN_W-1:0]     res_bin;
	logic [OUT_W-1:0]     res_bin_sum;
	logic [OUT_W-1:0]     res_total;
	logic                 res_sat;

	ebtl_bin_locate u_locate (
		.energy (energy),
		.bin    (hit_bin)
	);

	assign hit_in = (cmd == CMD_ACC) && is_neutron && (step_length != '0);
	assign rd_bin = hit_in ? hit_bin : ((read_bin > LAST_BIN) ? LAST_BIN : read_bin);

	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign clr_s1    = (cmd_s1 == CMD_CLEAR);

	ebtl_sum_mem #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_addr (ADDR_W'(rd_bin)),
		.rd_data (mem_rd_data),
		.wr_en   (advance && hit_s1),
		.wr_addr (ADDR_W'(bin_s1)),
		.wr_data (new_bin_sum),
		.clr     (advance && clr_s1)
	);

	// The memory returns the old word when the item ahead writes the same bin
	// (or clears the store) on the edge of the read, so the written value is carried along.
	assign fwd_next = advance && (clr_s1 || (hit_s1 && (bin_s1 == rd_bin)));

	assign old_sum     = fwd_s1 ? fwd_data_s1 : mem_rd_data;
	assign bin_add     = {1'b0, old_sum} + (SUM_WIDTH + 1)'(len_s1);
	assign tot_add     = {1'b0, total_q} + (SUM_WIDTH + 1)'(len_s1);
	assign new_bin_sum = bin_add[SUM_WIDTH] ? SUM_MAX : bin_add[SUM_WIDTH-1:0];
	assign new_total   = tot_add[SUM_WIDTH] ? SUM_MAX : tot_add[SUM_WIDTH-1:0];

	always_comb begin
		res_accepted = 1'b0;
		res_bin      = '0;
		res_bin_sum  = '0;
		res_total    = OUT_W'(total_q);
		res_sat      = 1'b0;
		case (cmd_s1)
			CMD_ACC: begin
				if (hit_s1) begin
					res_accepted = 1'b1;
					res_bin      = bin_s1;
					res_bin_sum  = OUT_W'(new_bin_sum);
					res_total    = OUT_W'(new_total);
					res_sat      = (new_bin_sum == SUM_MAX) || (new_total == SUM_MAX);
				end
			end
			CMD_CLEAR: begin
				res_total = '0;
			end
			CMD_READ: begin
				res_bin     = bin_s1;
				res_bin_sum = OUT_W'(old_sum);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
			total_q   <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (advance && clr_s1) begin
				total_q <= '0;
			end else if (advance && hit_s1) begin
				total_q <= new_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1      <= cmd;
			hit_s1      <= hit_in;
			len_s1      <= step_length;
			bin_s1      <= rd_bin;
			fwd_s1      <= fwd_next;
			fwd_data_s1 <= clr_s1 ? '0 : new_bin_sum;
		end
		if (advance) begin
			accepted  <= res_accepted;
			bin_index <= res_bin;
			bin_sum   <= res_bin_sum;
			total_sum <= res_total;
			saturated <= res_sat;
		end
	end

	// A clear that leaves the pipeline zeroes the total.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && clr_s1 |=> total_q == '0)
		else $error("total not zero after clear");

	// Accumulation never lowers the running total.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit_s1 && !clr_s1 |=> total_q >= $past(total_q))
		else $error("running total decreased");

	// A saturation flag only comes with an accumulated hit in a valid bin.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> accepted && (bin_index <= LAST_BIN))
		else $error("saturated flag without accumulated hit");

	// The input side is held back only while an item waits in the read stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without cause");

endmodule

/* rtl/ebtl_bin_locate.sv */
`timescale 1ns / 1ps
// Energy bin lookup: compares the energy against every edge in parallel.
// Depends on ebtl_pkg for the edge table and widths.
module ebtl_bin_locate
	import ebtl_pkg::*;
(
	input  logic [ENERGY_W-1:0] energy,
	output logic [BIN_W-1:0]    bin
);

	logic [NUM_EDGES-1:0] at_or_above;
	logic [BIN_W-1:0]     count;

	always_comb begin
		for (int i = 0; i < NUM_EDGES; i++) begin
			at_or_above[i] = (energy >= EDGES[i]);
		end
	end

	// The edges rise monotonically, so the compare vector is a thermometer code.
	assign count = BIN_W'($countones(at_or_above));

	always_comb begin
		if (count == '0) begin
			bin = '0;
		end else if ((count - 1'b1) > LAST_BIN) begin
			bin = LAST_BIN;
		end else begin
			bin = count - 1'b1;
		end
	end

endmodule

/* rtl/ebtl_sum_mem.sv */
`timescale 1ns / 1ps
// Bin sum store: synchronous memory with one write and one registered read port.
// Per-entry valid bits make unwritten or cleared entries read as zero. Uses ebtl_pkg.
module ebtl_sum_mem
	import ebtl_pkg::*;
#(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [SUM_WIDTH-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [SUM_WIDTH-1:0] wr_data,
	input  logic                 clr
);

	logic [SUM_WIDTH-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]  valid_q;
	logic [SUM_WIDTH-1:0] rd_word_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for energy_binned_track_length_histogram_unit.
// Keeps its own model of the bin sums and the total, and checks every result item.
// Depends on ebtl_pkg and the histogram unit RTL only.
module testbench;
	import ebtl_pkg::*;

	localparam int SUM_W = SUM_WIDTH_DEF;
	localparam logic [63:0] SUM_CEILING = {64{1'b1}} >> (64 - SUM_W);
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1000;
	localparam int STEADY_ITEMS = 150;
	localparam int LARGE_HITS = 40;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic                is_neutron;
		logic [ENERGY_W-1:0] energy;
		logic [LEN_W-1:0]    step_length;
		logic [BIN_W-1:0]    read_bin;
	} hit_t;

	typedef struct packed {
		logic             accepted;
		logic [BIN_W-1:0] bin_index;
		logic [OUT_W-1:0] bin_sum;
		logic [OUT_W-1:0] total_sum;
		logic             saturated;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = CMD_ACC;
	logic is_neutron = 1'b0;
	logic [ENERGY_W-1:0] energy = '0;
	logic [LEN_W-1:0] step_length = '0;
	logic [BIN_W-1:0] read_bin = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accepted;
	logic [BIN_W-1:0] bin_index;
	logic [OUT_W-1:0] bin_sum;
	logic [OUT_W-1:0] total_sum;
	logic saturated;

	// Model of the histogram state, kept at full sum width.
	logic [63:0] bin_track_len [NUM_BINS];
	logic [63:0] total_track_len;
	tally_t expected_tallies [$];

	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned hits_taken = 0;
	int unsigned hits_dropped = 0;
	int unsigned saturated_hits = 0;
	int unsigned clears_done = 0;
	int unsigned reads_done = 0;
	logic [ENERGY_W-1:0] last_energy = '0;

	energy_binned_track_length_histogram_unit #(
		.SUM_WIDTH(SUM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.is_neutron(is_neutron),
		.energy(energy),
		.step_length(step_length),
		.read_bin(read_bin),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.bin_index(bin_index),
		.bin_sum(bin_sum),
		.total_sum(total_sum),
		.saturated(saturated)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] saturating_add(input logic [63:0] a, input logic [63:0] b);
		if (b > SUM_CEILING - a)
			return SUM_CEILING;
		return a + b;
	endfunction

	function automatic tally_t predict_tally(input hit_t h);
		tally_t t;
		int unsigned b;
		t = '0;
		if (h.cmd == CMD_ACC && h.is_neutron && h.step_length != '0) begin
			b = 0;
			for (int i = 0; i < NUM_EDGES; i++)
				if (EDGES[i] <= h.energy)
					b++;
			b = (b == 0) ? 0 : b - 1;
			if (b > NUM_BINS - 1)
				b = NUM_BINS - 1;
			bin_track_len[b] = saturating_add(bin_track_len[b], 64'(h.step_length));
			total_track_len = saturating_add(total_track_len, 64'(h.step_length));
			t.accepted = 1'b1;
			t.bin_index = BIN_W'(b);
			t.bin_sum = bin_track_len[b][OUT_W-1:0];
			t.saturated = (bin_track_len[b] == SUM_CEILING || total_track_len == SUM_CEILING);
			hits_taken++;
			if (t.saturated)
				saturated_hits++;
		end else if (h.cmd == CMD_CLEAR) begin
			foreach (bin_track_len[i])
				bin_track_len[i] = '0;
			total_track_len = '0;
			clears_done++;
		end else if (h.cmd == CMD_READ) begin
			b = (h.read_bin > LAST_BIN) ? NUM_BINS - 1 : h.read_bin;
			t.bin_index = BIN_W'(b);
			t.bin_sum = bin_track_len[b][OUT_W-1:0];
			reads_done++;
		end else begin
			hits_dropped++;
		end
		t.total_sum = total_track_len[OUT_W-1:0];
		return t;
	endfunction

	// Presents one item, with an occasional gap before it, and records the
	// expected result once the item has been taken.
	task automatic send_hit(input logic [CMD_W-1:0] c, input logic n,
			input logic [ENERGY_W-1:0] e, input logic [LEN_W-1:0] len,
			input logic [BIN_W-1:0] rb);
		hit_t h;
		h.cmd = c;
		h.is_neutron = n;
		h.energy = e;
		h.step_length = len;
		h.read_bin = rb;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		is_neutron <= n;
		energy <= e;
		step_length <= len;
		read_bin <= rb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_tallies.push_back(predict_tally(h));
	endtask

	function automatic logic [ENERGY_W-1:0] pick_energy();
		logic [63:0] raw;
		int unsigned k;
		raw = {$urandom(), $urandom()};
		k = $urandom_range(0, NUM_EDGES - 1);
		case ($urandom_range(0, 4))
			0, 1: return EDGES[k] + ENERGY_W'($urandom_range(0, 2)) - ENERGY_W'(1);
			2: return raw[ENERGY_W-1:0] >> $urandom_range(0, ENERGY_W - 1);
			3: return raw[ENERGY_W-1:0];
			default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return LEN_W'($urandom_range(1, 255));
			default: return $urandom();
		endcase
	endfunction

	// Mostly hits, with reads, rare clears and a few dropped or unused items.
	// Only items that change or report state count towards the goal.
	task automatic run_random_items(input int unsigned goal);
		int unsigned counted;
		int unsigned roll;
		logic [CMD_W-1:0] c;
		logic n;
		logic [LEN_W-1:0] len;
		logic [ENERGY_W-1:0] e;
		logic [BIN_W-1:0] rb;
		counted = 0;
		while (counted < goal) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				c = CMD_ACC;
			else if (roll < 72)
				c = CMD_CLEAR;
			else if (roll < 94)
				c = CMD_READ;
			else
				c = CMD_UNUSED;
			n = ($urandom_range(0, 7) != 0);
			len = pick_length();
			// Repeating an energy sends hits to the same bin back to back.
			e = ($urandom_range(0, 3) == 0) ? last_energy : pick_energy();
			last_energy = e;
			rb = ($urandom_range(0, 3) == 0) ? BIN_W'($urandom_range(0, 63))
				: BIN_W'($urandom_range(0, NUM_BINS - 1));
			if (c == CMD_CLEAR || c == CMD_READ || (c == CMD_ACC && n && len != '0))
				counted++;
			send_hit(c, n, e, len, rb);
		end
	endtask

	task automatic test_after_reset();
		send_hit(CMD_READ, 1'b0, '0, '0, '0);
		send_hit(CMD_READ, 1'b1, '1, '1, '1);
		send_hit(CMD_READ, 1'b0, '0, '0, LAST_BIN);
	endtask

	task automatic test_directed();
		send_hit(CMD_ACC, 1'b1, '0, 32'd1, '0);
		send_hit(CMD_ACC, 1'b1, EDGES[0], 32'h0001_0000, '0);
		send_hit(CMD_ACC, 1'b1, EDGES[1] - 1, 32'd3, '0);
		send_hit(CMD_ACC, 1'b1, EDGES[1], 32'd5, '0);
		send_hit(CMD_ACC, 1'b1, EDGES[NUM_EDGES-1] - 1, 32'd7, '0);
		send_hit(CMD_ACC, 1'b1, EDGES[NUM_EDGES-1], 32'd11, '0);
		send_hit(CMD_ACC, 1'b1, '1, '1, '1);
		// A hit from another particle and a zero-length hit leave the sums alone.
		send_hit(CMD_ACC, 1'b0, EDGES[3], 32'd5, '0);
		send_hit(CMD_ACC, 1'b1, EDGES[3], '0, '0);
		send_hit(CMD_UNUSED, 1'b1, EDGES[3], 32'd9, 6'd3);
		send_hit(CMD_READ, 1'b0, '0, '0, LAST_BIN);
		send_hit(CMD_READ, 1'b0, '0, '0, BIN_W'(NUM_BINS));
		send_hit(CMD_READ, 1'b0, '0, '0, 6'd1);
		send_hit(CMD_READ, 1'b0, '0, '0, 6'd3);
		send_hit(CMD_CLEAR, 1'b1, '1, '1, '1);
		send_hit(CMD_READ, 1'b0, '0, '0, LAST_BIN);
		send_hit(CMD_ACC, 1'b1, EDGES[8], 32'hAAAA_AAAA, 6'b101010);
		send_hit(CMD_ACC, 1'b1, EDGES[16] - 1, 32'h5555_5555, 6'b010101);
		send_hit(CMD_ACC, 1'b1, EDGES[8], 32'h5555_5555, '0);
		send_hit(CMD_READ, 1'b1, 44'hAAA_AAAA_AAAA, 32'hAAAA_AAAA, 6'b101010);
		send_hit(CMD_READ, 1'b0, 44'h555_5555_5555, 32'h5555_5555, 6'b010101);
		send_hit(CMD_READ, 1'b0, '0, '0, 6'd8);
		send_hit(CMD_CLEAR, 1'b0, '0, '0, '0);
	endtask

	task automatic test_random_stream();
		run_random_items(RANDOM_ITEMS);
	endtask

	// Full-length hits back to back into the top bin, then hits into the lowest
	// bin, with reads before and after a clear.
	task automatic test_large_steps();
		send_hit(CMD_CLEAR, 1'b0, '0, '0, '0);
		for (int i = 0; i < LARGE_HITS; i++)
			send_hit(CMD_ACC, 1'b1, '1, '1, '0);
		send_hit(CMD_READ, 1'b0, '0, '0, LAST_BIN);
		send_hit(CMD_ACC, 1'b1, '0, 32'd1, '0);
		send_hit(CMD_ACC, 1'b1, '0, '1, '0);
		send_hit(CMD_READ, 1'b0, '0, '0, '0);
		send_hit(CMD_CLEAR, 1'b0, '0, '0, '0);
		send_hit(CMD_READ, 1'b0, '0, '0, LAST_BIN);
	endtask

	task automatic test_steady_stream();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_random_items(STEADY_ITEMS);
	endtask

	// Random stall bursts on the result side while stalls are enabled.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		tally_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tallies.size() == 0) begin
				$error("result item with no input item outstanding");
				mismatches++;
			end else begin
				want = expected_tallies.pop_front();
				results_checked++;
				if (accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, accepted);
					mismatches++;
				end
				if (bin_index !== want.bin_index) begin
					$error("bin_index: expected %0d, got %0d", want.bin_index, bin_index);
					mismatches++;
				end
				if (bin_sum !== want.bin_sum) begin
					$error("bin_sum: expected %0h, got %0h", want.bin_sum, bin_sum);
					mismatches++;
				end
				if (total_sum !== want.total_sum) begin
					$error("total_sum: expected %0h, got %0h", want.total_sum, total_sum);
					mismatches++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d", want.saturated, saturated);
					mismatches++;
				end
			end
		end
	end

	// Ends the run if neither side moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL energy_binned_track_length_histogram_unit");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		foreach (bin_track_len[i])
			bin_track_len[i] = '0;
		total_track_len = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		test_after_reset();
		test_directed();
		test_random_stream();
		test_large_steps();
		test_steady_stream();
		in_valid <= 1'b0;
		while (expected_tallies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results: %0d hits summed (%0d at the ceiling), %0d dropped.",
			results_checked, hits_taken, saturated_hits, hits_dropped);
		$display("Also %0d clears and %0d bin reads; %0d mismatches.",
			clears_done, reads_done, mismatches);
		if (mismatches == 0)
			$display("PASS energy_binned_track_length_histogram_unit");
		else
			$display("FAIL energy_binned_track_length_histogram_unit");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ebtl_pkg.sv
rtl/ebtl_bin_locate.sv
rtl/ebtl_sum_mem.sv
rtl/energy_binned_track_length_histogram_unit.sv
test/testbench.sv
